[hdl/avm_pkg.sv]
// Package for the acceleration vector magnitude block: pipeline geometry,
// device kind codes, square root stage state and its step function.
// No dependencies.
package avm_pkg;

    // Device kind register codes
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_BIG16 = 2'd1;
    localparam logic [1:0] KIND_LE12  = 2'd2;

    localparam int AXES = 3;
    localparam int ABS_W = 16;
    localparam int SQR_W = 31;          // 32768^2 = 2^30
    localparam int SUM_W = 32;          // three squares
    localparam int RAD_W = 36;          // scaled sum of squares
    localparam int ROOT_W = 18;         // RAD_W / 2, Q2.16 magnitude
    localparam int REM_W = ROOT_W + 1;  // remainder never exceeds 2 * root
    localparam int SCALE_LE12_W = 13;
    localparam logic [SCALE_LE12_W-1:0] SCALE_LE12 = 13'd4295;

    localparam int STEPS_PER_STAGE = 2;
    localparam int SQRT_STAGES = ROOT_W / STEPS_PER_STAGE;
    // stage 0 decode, 1 squares, 2 sum, 3 scale, then the root stages
    localparam int PIPE_SQRT0 = 3;
    localparam int NSTAGE = PIPE_SQRT0 + SQRT_STAGES + 1;

    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sqrt_t;

    // Restoring square root: one result bit per step, two radicand bits in.
    function automatic sqrt_t sqrt_stage(sqrt_t s_in);
        sqrt_t s;
        logic [REM_W+1:0] cur;
        logic [REM_W+1:0] trial;
        s = s_in;
        for (int k = 0; k < STEPS_PER_STAGE; k++)
        begin
            cur = {s.rem, s.rad[RAD_W-1 -: 2]};
            trial = {1'b0, s.root, 2'b01};
            s.rad = {s.rad[RAD_W-3:0], 2'b00};
            if (cur >= trial)
            begin
                cur = cur - trial;
                s.root = {s.root[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                s.root = {s.root[ROOT_W-2:0], 1'b0};
            end
            s.rem = cur[REM_W-1:0];
        end
        return s;
    endfunction

endpackage

[hdl/accel_vector_magnitude_top.sv]
// Acceleration vector magnitude, top level: byte assembly, sum of squares,
// scaling and a pipelined integer square root.
// Depends on avm_pkg.

// Takes one six-byte accelerometer read per request (tdata bytes 0..5 in
// read order, tuser = read ok) and returns |a| in g as unsigned Q2.16 in
// tdata[17:0], with tuser = 1 when the result is meaningful. Device kind 1
// reads big-endian 16-bit axes at 16384 LSB/g, kind 2 little-endian words
// whose top 12 bits are the axis at 1 mg/LSB; kinds 0 and 3, or a failed
// read, return magnitude 0 with tuser = 0. One request is taken every cycle
// while stage 0 can load; stages: decode, squares, sum, scale, then nine root
// stages of two bits each, the 18-bit square root setting the depth. Each
// stage holds its data when the next is full, so empty slots close up under
// back-pressure. The user must write the device kind (reset value 0) through
// cfg_wr_en and cfg_wr_data only while no request is in flight (not enforced).
module accel_vector_magnitude_top
    import avm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // byte_0 .. byte_5 from bit 0 up
    input  logic        s_axis_tuser,   // read_ok
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // magnitude [17:0], zero padding above
    output logic        m_axis_tuser    // valid_res
);

    localparam int LAST = NSTAGE - 1;

    logic [1:0]             kind_reg;
    logic [NSTAGE-1:0]      vld_reg;
    logic [NSTAGE-1:0]      ok_reg;
    logic [NSTAGE-1:0]      adv;
    logic [PIPE_SQRT0-1:0]  big_reg;
    logic [ABS_W-1:0]       abs_reg [AXES];
    logic [ABS_W-1:0]       abs_next [AXES];
    logic [SQR_W-1:0]       sqr_reg [AXES];
    logic [SUM_W-1:0]       sum_reg;
    logic [RAD_W-1:0]       rad_next;
    sqrt_t                  sq_reg [SQRT_STAGES+1];
    logic                   ok_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= KIND_NONE;
        end
        else if (cfg_wr_en)
        begin
            kind_reg <= cfg_wr_data;
        end
    end

    // A stage may load when it is empty or its content moves on
    always_comb
    begin
        adv[LAST] = !vld_reg[LAST] || m_axis_tready;
        for (int i = LAST - 1; i >= 0; i--)
        begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    assign s_axis_tready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= s_axis_tvalid;
            end
            for (int i = 1; i < NSTAGE; i++)
            begin
                if (adv[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // Stage 0: assemble axes and take absolute values; invalid reads give zeros
    assign ok_next = s_axis_tuser && (kind_reg == KIND_BIG16 || kind_reg == KIND_LE12);

    for (genvar g = 0; g < AXES; g++)
    begin : g_axis
        logic [7:0]  first_b;
        logic [7:0]  second_b;
        logic [15:0] w_be;
        logic [11:0] v_le;
        logic [15:0] abs_be;
        logic [11:0] abs_le;

        assign first_b = s_axis_tdata[16*g +: 8];
        assign second_b = s_axis_tdata[16*g+8 +: 8];
        assign w_be = {first_b, second_b};
        assign v_le = {second_b, first_b[7:4]};
        assign abs_be = w_be[15] ? (~w_be + 16'd1) : w_be;
        assign abs_le = v_le[11] ? (~v_le + 12'd1) : v_le;

        always_comb
        begin
            if (!ok_next)
            begin
                abs_next[g] = '0;
            end
            else if (kind_reg == KIND_BIG16)
            begin
                abs_next[g] = abs_be;
            end
            else
            begin
                abs_next[g] = {4'd0, abs_le};
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv[0])
            begin
                abs_reg[g] <= abs_next[g];
            end
            if (adv[1])
            begin
                sqr_reg[g] <= SQR_W'(abs_reg[g] * abs_reg[g]);
            end
        end
    end

    // Stage 3 radicand: 16*S for kind 1, 4295*S for kind 2
    assign rad_next = big_reg[2] ? {sum_reg, 4'd0}
                                 : RAD_W'(sum_reg * SCALE_LE12);

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            ok_reg[0] <= ok_next;
            big_reg[0] <= (kind_reg == KIND_BIG16);
        end
        for (int i = 1; i < NSTAGE; i++)
        begin
            if (adv[i])
            begin
                ok_reg[i] <= ok_reg[i-1];
            end
        end
        for (int i = 1; i < PIPE_SQRT0; i++)
        begin
            if (adv[i])
            begin
                big_reg[i] <= big_reg[i-1];
            end
        end
        if (adv[2])
        begin
            sum_reg <= SUM_W'(sqr_reg[0]) + SUM_W'(sqr_reg[1]) + SUM_W'(sqr_reg[2]);
        end
        if (adv[PIPE_SQRT0])
        begin
            sq_reg[0].rad <= rad_next;
            sq_reg[0].rem <= '0;
            sq_reg[0].root <= '0;
        end
    end

    for (genvar g = 1; g <= SQRT_STAGES; g++)
    begin : g_root
        always_ff @(posedge clk)
        begin
            if (adv[PIPE_SQRT0+g])
            begin
                sq_reg[g] <= sqrt_stage(sq_reg[g-1]);
            end
        end
    end

    assign m_axis_tvalid = vld_reg[LAST];
    assign m_axis_tdata = {6'd0, sq_reg[SQRT_STAGES].root};
    assign m_axis_tuser = ok_reg[LAST];

    // An invalid result carries a zero magnitude
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 24'd0)
        else $error("invalid result with non-zero magnitude");

    // Input is refused only when every stage, the output included, is occupied
    a_full_only: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> vld_reg == {NSTAGE{1'b1}} && !m_axis_tready)
        else $error("input refused with room in the pipeline");

    // Failed or unconfigured reads enter the datapath as zero axes
    a_zero_axes: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[0] && !ok_reg[0] |-> abs_reg[0] == '0 && abs_reg[1] == '0
                                     && abs_reg[2] == '0)
        else $error("invalid request with non-zero axis");

endmodule
